// ===== design/ttlhs_pkg.sv =====
package ttlhs_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_PULSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END         = 3'd5;

    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 16;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] RST_FIRST_WAIT  = 32'd30000000;
    localparam logic [CNT_W-1:0] RST_REPLY_WAIT  = 32'd5000000;
    localparam logic [LEN_W-1:0] RST_REPLY_PULSE = 16'd5;
    localparam logic [LEN_W-1:0] RST_REPLY_GAP   = 16'd10;
    localparam logic [LEN_W-1:0] RST_LAUNCH      = 16'd30;
    localparam logic [LEN_W-1:0] RST_END         = 16'd10;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_WAIT_FIRST = 4'd1,
        PH_REPLY      = 4'd2,
        PH_GAP        = 4'd3,
        PH_WAIT_RESP  = 4'd4,
        PH_WAIT_READY = 4'd5,
        PH_LAUNCH     = 4'd6,
        PH_WAIT_END   = 4'd7,
        PH_END_PULSE  = 4'd8,
        PH_DONE       = 4'd9
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] first_wait_limit;
        logic [CNT_W-1:0] reply_wait_limit;
        logic [LEN_W-1:0] reply_pulse_len;
        logic [LEN_W-1:0] reply_gap_len;
        logic [LEN_W-1:0] launch_pulse_len;
        logic [LEN_W-1:0] end_pulse_len;
    } t_cfg;

    typedef struct packed {
        logic start_req;
        logic console_in;
    } t_in_beat;

    typedef struct packed {
        logic       launch_out;
        logic       console_out;
        logic [3:0] phase;
        logic       timed_out;
        logic       finished;
    } t_out_beat;

endpackage

// ===== design/ttlhs_cfg_regs.sv =====
module ttlhs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [ttlhs_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [ttlhs_pkg::CFG_DATA_W-1:0]   i_data,
    output ttlhs_pkg::t_cfg                    o_cfg
);
    import ttlhs_pkg::*;

    t_cfg r_cfg;

    // Register file; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_wait_limit <= RST_FIRST_WAIT;
            r_cfg.reply_wait_limit <= RST_REPLY_WAIT;
            r_cfg.reply_pulse_len  <= RST_REPLY_PULSE;
            r_cfg.reply_gap_len    <= RST_REPLY_GAP;
            r_cfg.launch_pulse_len <= RST_LAUNCH;
            r_cfg.end_pulse_len    <= RST_END;
        end else if (i_wr) begin
            case (i_index)
                CFG_FIRST_WAIT:  r_cfg.first_wait_limit <= i_data;
                CFG_REPLY_WAIT:  r_cfg.reply_wait_limit <= i_data;
                CFG_REPLY_PULSE: r_cfg.reply_pulse_len  <= i_data[LEN_W-1:0];
                CFG_REPLY_GAP:   r_cfg.reply_gap_len    <= i_data[LEN_W-1:0];
                CFG_LAUNCH:      r_cfg.launch_pulse_len <= i_data[LEN_W-1:0];
                CFG_END:         r_cfg.end_pulse_len    <= i_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/ttlhs_seq_core.sv =====
module ttlhs_seq_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  ttlhs_pkg::t_in_beat   i_beat,
    input  ttlhs_pkg::t_cfg       i_cfg,
    output ttlhs_pkg::t_out_beat  o_beat
);
    import ttlhs_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_flag,  n_flag;
    logic             n_fin;

    logic [CNT_W-1:0] cnt_inc;
    logic [LEN_W:0]   pulse_gap_end;

    // Saturating tick counter increment
    assign cnt_inc       = (r_count == '1) ? r_count : r_count + 1'b1;
    assign pulse_gap_end = {1'b0, i_cfg.reply_pulse_len} + {1'b0, i_cfg.reply_gap_len};

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_flag  = r_flag;
        n_fin   = 1'b0;
        case (r_phase)
            PH_WAIT_FIRST: begin
                if (i_beat.console_in) begin
                    n_phase = PH_REPLY;
                    n_count = CNT_W'(1);
                end else if (cnt_inc > i_cfg.first_wait_limit) begin
                    n_flag  = 1'b1;
                    n_phase = PH_WAIT_END;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_REPLY, PH_GAP: begin
                n_count = cnt_inc;
                if (cnt_inc <= CNT_W'(i_cfg.reply_pulse_len))
                    n_phase = PH_REPLY;
                else if (cnt_inc <= CNT_W'(pulse_gap_end))
                    n_phase = PH_GAP;
                else
                    n_phase = PH_WAIT_RESP;
            end
            PH_WAIT_RESP: begin
                if (i_beat.console_in) begin
                    n_phase = PH_WAIT_READY;
                    n_count = '0;
                end else if (cnt_inc > i_cfg.reply_wait_limit) begin
                    n_flag  = 1'b1;
                    n_phase = PH_WAIT_END;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_WAIT_READY: begin
                if (i_beat.console_in) begin
                    n_phase = PH_LAUNCH;
                    n_count = CNT_W'(1);
                end
            end
            PH_LAUNCH: begin
                if (cnt_inc > CNT_W'(i_cfg.launch_pulse_len)) begin
                    n_phase = PH_WAIT_END;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_WAIT_END: begin
                if (i_beat.console_in) begin
                    n_phase = PH_END_PULSE;
                    n_count = CNT_W'(1);
                end
            end
            PH_END_PULSE: begin
                if (cnt_inc > CNT_W'(i_cfg.end_pulse_len)) begin
                    n_phase = PH_DONE;
                    n_count = '0;
                    n_fin   = 1'b1;
                end else begin
                    n_count = cnt_inc;
                end
            end
            default: begin
                // idle or done: a start request opens a new run
                if (i_beat.start_req) begin
                    n_phase = PH_WAIT_FIRST;
                    n_count = '0;
                    n_flag  = 1'b0;
                end else if (r_phase != PH_DONE) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Result fields, decoded from the phase being entered
    always_comb begin
        o_beat.launch_out  = (n_phase == PH_LAUNCH) || (n_phase == PH_END_PULSE);
        o_beat.console_out = (n_phase == PH_REPLY)  || (n_phase == PH_LAUNCH);
        o_beat.phase       = n_phase;
        o_beat.timed_out   = n_flag;
        o_beat.finished    = n_fin;
    end

    // State registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

endmodule

// ===== design/ttlhs_out_reg.sv =====
module ttlhs_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ttlhs_pkg::t_out_beat  i_beat,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ttlhs_pkg::t_out_beat  o_beat
);
    import ttlhs_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    // Room for a new beat when empty or the held beat leaves this cycle
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== design/ttl_trigger_handshake_sequencer_top.sv =====
// TTL trigger handshake sequencer.
// Input channel (i_in_valid / o_in_ready / i_in): one beat per time tick,
// carrying the start request and the sampled console level.
// Output channel (o_out_valid / i_out_ready / o_out): one beat per input
// beat, giving the line levels, phase, timeout flag and finish strobe of
// the phase entered on that tick.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data): always ready; write only while the block is idle.
// A result beat is registered and valid the cycle after its input beat is taken.
// Throughput: one beat per cycle while i_out_ready stays high; the sequencer
// step is one counter increment and the 32-bit compares of the current phase,
// between the state registers and the output register.
// Reset: configuration returns to defaults, the sequencer goes idle with
// the counter and timeout flag cleared, and the output register empties.
// Stall: when the receiver holds i_out_ready low, the output register keeps
// its beat and o_in_ready drops until that beat is taken.
module ttl_trigger_handshake_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ttlhs_pkg::t_in_beat               i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ttlhs_pkg::t_out_beat              o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ttlhs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttlhs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ttlhs_pkg::*;

    t_cfg      cfg;
    t_out_beat step_beat;
    logic      space;
    logic      in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign in_accept   = i_in_valid && space;

    ttlhs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ttlhs_seq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_beat  (i_in),
        .i_cfg   (cfg),
        .o_beat  (step_beat)
    );

    ttlhs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_beat  (step_beat),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out)
    );

endmodule

// ===== design/ttlhs_checker.sv =====
module ttlhs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  ttlhs_pkg::t_out_beat              o_out
);
    import ttlhs_pkg::*;

    // Finish strobe only with the done phase
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.finished |-> o_out.phase == PH_DONE)
        else $error("finish strobe outside done phase");

    // Launch line follows launch and end pulse phases
    a_launch_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.launch_out ==
            ((o_out.phase == PH_LAUNCH) || (o_out.phase == PH_END_PULSE)))
        else $error("launch line does not match phase");

    // Console line follows reply and launch phases
    a_console_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.console_out ==
            ((o_out.phase == PH_REPLY) || (o_out.phase == PH_LAUNCH)))
        else $error("console line does not match phase");

    // An accepted tick always yields a result beat next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted tick produced no result beat");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

endmodule

bind ttl_trigger_handshake_sequencer_top ttlhs_checker u_chk (.*);
